FILE: sv/fts_pkg.sv
// ----------------------------------------------------------------------------
// fts_pkg
// Shared types and field widths for the FIFO task server.
// ----------------------------------------------------------------------------
package fts_pkg;

    localparam int ID_W      = 16;
    localparam int TICK_W    = 16;
    localparam int SVC_W     = 4;
    localparam int WAIT_W    = 16;
    localparam int TOTAL_W   = 32;
    localparam int LEVEL_W   = 5;

    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 88;

    // One queued task; svc holds the remaining service of the head task
    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [TICK_W-1:0] arrival;
        logic [SVC_W-1:0]  svc;
    } fts_entry_t;

    // Result of one tick
    typedef struct packed {
        logic               served_valid;
        logic [ID_W-1:0]    served_id;
        logic               completed;
        logic [WAIT_W-1:0]  task_wait;
        logic [TOTAL_W-1:0] wait_total;
        logic [ID_W-1:0]    tasks_arrived;
        logic [LEVEL_W-1:0] queue_level;
        logic               dropped;
    } fts_result_t;

endpackage

FILE: sv/fts_ram.sv
// ----------------------------------------------------------------------------
// fts_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module fts_ram #(
    parameter int WIDTH  = 36,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read returns the old contents on a same-address write
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

FILE: sv/fts_engine.sv
// ----------------------------------------------------------------------------
// fts_engine
// Per-tick queue update: enqueue at tail, serve the head, keep statistics.
// ----------------------------------------------------------------------------
module fts_engine #(
    parameter int QUEUE_DEPTH = 16,
    parameter int MAX_SERVICE = 8
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    fire,
    input  logic                    arrival_valid,
    input  logic [3:0]              service_time,
    output fts_pkg::fts_result_t    result
);
    import fts_pkg::*;

    localparam int PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int SVC_CAP = (MAX_SERVICE > 15) ? 15 : MAX_SERVICE;
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

    function automatic logic [PTR_W-1:0] adv_ptr(input logic [PTR_W-1:0] p);
        adv_ptr = (p == LAST_PTR) ? '0 : p + 1'b1;
    endfunction

    logic [PTR_W-1:0]   head_ptr_reg, head_ptr_next;
    logic [PTR_W-1:0]   tail_ptr_reg, tail_ptr_next;
    logic [CNT_W-1:0]   fill_reg, fill_next;
    logic [TICK_W-1:0]  tick_reg, tick_next;
    logic [ID_W-1:0]    next_id_reg, next_id_next;
    logic [TOTAL_W-1:0] wait_sum_reg, wait_sum_next;
    fts_entry_t         head_reg, head_next;
    logic               byp_valid_reg, byp_valid_next;
    fts_entry_t         byp_data_reg, byp_data_next;

    logic [SVC_W-1:0]   svc_clamp;
    logic               full;
    logic               enq;
    logic               have_head;
    logic               done;
    fts_entry_t         new_entry;
    fts_entry_t         cur;
    fts_entry_t         nxt;
    fts_entry_t         ram_q;
    logic [SVC_W-1:0]   rem_dec;
    logic [TOTAL_W:0]   sum_wide;
    logic [TOTAL_W-1:0] sum_sat;
    logic [PTR_W-1:0]   head_ptr_eff;
    logic [PTR_W-1:0]   rd_addr;
    logic               wr_en;

    always_comb
    begin
        if (service_time == '0)
        begin
            svc_clamp = SVC_W'(1);
        end
        else if (int'(service_time) > SVC_CAP)
        begin
            svc_clamp = SVC_W'(SVC_CAP);
        end
        else
        begin
            svc_clamp = service_time;
        end
    end

    assign full      = (fill_reg == CNT_W'(QUEUE_DEPTH));
    assign enq       = arrival_valid && !full;
    assign new_entry = '{id: next_id_reg, arrival: tick_reg, svc: svc_clamp};

    // Head is the stored head, or the arriving task when the queue was empty
    assign have_head = (fill_reg != '0) || enq;
    assign cur       = (fill_reg == '0) ? new_entry : head_reg;
    assign rem_dec   = cur.svc - 1'b1;
    assign done      = have_head && (rem_dec == '0);

    assign nxt       = byp_valid_reg ? byp_data_reg : ram_q;

    assign sum_wide  = {1'b0, wait_sum_reg} + {{(TOTAL_W + 1 - TICK_W){1'b0}},
                                               tick_reg - cur.arrival};
    assign sum_sat   = sum_wide[TOTAL_W] ? '1 : sum_wide[TOTAL_W-1:0];

    always_comb
    begin
        tail_ptr_next = enq ? adv_ptr(tail_ptr_reg) : tail_ptr_reg;
        head_ptr_next = done ? adv_ptr(head_ptr_reg) : head_ptr_reg;
        fill_next     = fill_reg + CNT_W'(enq) - CNT_W'(done);
        next_id_next  = next_id_reg + ID_W'(enq);
        tick_next     = tick_reg + 1'b1;
        wait_sum_next = done ? sum_sat : wait_sum_reg;

        if (done)
        begin
            // Promote the next task; it is served first on the following tick
            head_next = (fill_reg > CNT_W'(1)) ? nxt : new_entry;
        end
        else if (have_head)
        begin
            head_next     = cur;
            head_next.svc = rem_dec;
        end
        else
        begin
            head_next = head_reg;
        end
    end

    // Keep the RAM output pointed at the entry after the head
    assign head_ptr_eff   = fire ? head_ptr_next : head_ptr_reg;
    assign rd_addr        = adv_ptr(head_ptr_eff);
    assign wr_en          = fire && enq;
    assign byp_valid_next = wr_en && (tail_ptr_reg == rd_addr);
    assign byp_data_next  = new_entry;

    fts_ram #(
        .WIDTH  ($bits(fts_entry_t)),
        .DEPTH  (QUEUE_DEPTH),
        .ADDR_W (PTR_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (tail_ptr_reg),
        .wr_data (new_entry),
        .rd_addr (rd_addr),
        .rd_data (ram_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_ptr_reg  <= '0;
            tail_ptr_reg  <= '0;
            fill_reg      <= '0;
            tick_reg      <= '0;
            next_id_reg   <= '0;
            wait_sum_reg  <= '0;
            byp_valid_reg <= 1'b0;
        end
        else
        begin
            byp_valid_reg <= byp_valid_next;
            if (fire)
            begin
                head_ptr_reg <= head_ptr_next;
                tail_ptr_reg <= tail_ptr_next;
                fill_reg     <= fill_next;
                tick_reg     <= tick_next;
                next_id_reg  <= next_id_next;
                wait_sum_reg <= wait_sum_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        byp_data_reg <= byp_data_next;
        if (fire)
        begin
            head_reg <= head_next;
        end
    end

    always_comb
    begin
        result.served_valid  = have_head;
        result.served_id     = have_head ? cur.id : '0;
        result.completed     = done;
        result.task_wait     = done ? (tick_reg - cur.arrival) : '0;
        result.wait_total    = wait_sum_next;
        result.tasks_arrived = next_id_next;
        result.queue_level   = LEVEL_W'(fill_next);
        result.dropped       = arrival_valid && full;
    end

endmodule

FILE: sv/fifo_task_server_with_wait_stats.sv
// ----------------------------------------------------------------------------
// fifo_task_server_with_wait_stats
// Single-server FIFO task queue with wait-time statistics, one tick per item.
// ----------------------------------------------------------------------------
// Every input transaction is one tick. It may carry a new task; the task gets
// the next id and the current tick as its arrival stamp and joins the queue,
// or is dropped and flagged when all QUEUE_DEPTH slots are in use. The head
// task then receives one tick of service; when it finishes, its wait (tick
// minus arrival, modulo 2^16) is added to a saturating 32-bit total and it
// leaves. Every input transaction yields exactly one output transaction, in
// the cycle after it is accepted. The block takes one transaction per clock
// cycle unless stalled; the figure is set by the tick update path (tail write,
// head decrement and the 33-bit saturating add) between the queue state
// registers and the output register. Task slots live in a RAM that needs no
// clearing after reset, so the block accepts input from the first cycle.
// ----------------------------------------------------------------------------
module fifo_task_server_with_wait_stats #(
    parameter int QUEUE_DEPTH = 16,
    parameter int MAX_SERVICE = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [0] arrival_valid, [4:1] service_time, [7:5] zero
    input  logic [7:0]  s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] served_valid, [16:1] served_id, [17] completed, [33:18] task_wait,
    // [65:34] wait_total, [81:66] tasks_arrived, [86:82] queue_level,
    // [87] dropped
    output logic [87:0] m_tdata
);
    import fts_pkg::*;

    logic        in_fire;
    logic        out_valid_reg, out_valid_next;
    logic [OUT_TDATA_W-1:0] out_data_reg;
    fts_result_t result;

    // Accept a new transaction whenever the output register is free or drains
    assign s_tready = !out_valid_reg || m_tready;
    assign in_fire  = s_tvalid && s_tready;

    fts_engine #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .MAX_SERVICE (MAX_SERVICE)
    ) u_engine (
        .clk           (clk),
        .rst_n         (rst_n),
        .fire          (in_fire),
        .arrival_valid (s_tdata[0]),
        .service_time  (s_tdata[4:1]),
        .result        (result)
    );

    always_comb
    begin
        if (in_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold the result until the downstream side takes it
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            out_data_reg <= {result.dropped,
                             result.queue_level,
                             result.tasks_arrived,
                             result.wait_total,
                             result.task_wait,
                             result.completed,
                             result.served_id,
                             result.served_valid};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking regression for the FIFO task server with wait statistics.
// ----------------------------------------------------------------------------
// Every input transaction is one tick of the server. A small tracker class
// keeps its own copy of the queue (slots, pointers, tick and id counters and
// the saturating wait sum). For each accepted input it computes the result of
// that tick and queues it. Each accepted output is compared field by field
// with the oldest queued result.
//
// Stimulus starts with a short directed run:
//   - ticks with no arrival on an empty queue
//   - service times of zero and above the maximum, which must be clamped
//   - a long string of arrivals that fills the queue and forces drops
// A random run of bursts follows. The bursts use light, heavy, balanced and
// noisy load profiles. The receiver stalls in changing patterns. Once it
// holds off for a long stretch while input keeps coming, and once the sender
// pauses until every expected result has arrived.
// ----------------------------------------------------------------------------
module tb_top;

    import fts_pkg::*;

    localparam int QUEUE_DEPTH  = 16;
    localparam int MAX_SERVICE  = 8;
    localparam int RANDOM_TICKS = 1525;
    localparam int HOLD_AT      = 400;     // random tick that starts the long stall
    localparam int DRAIN_AT     = 900;     // random tick after which input pauses
    localparam int HOLD_CYCLES  = 250;
    localparam int SETTLE       = 10;      // settling margin after the drain
    localparam int CYCLE_LIMIT  = 400000;

    typedef enum int {LOAD_LIGHT, LOAD_HEAVY, LOAD_BALANCED, LOAD_NOISE} load_profile_t;
    typedef enum int {RX_ALWAYS, RX_MOSTLY, RX_PATTERN, RX_SPARSE} rx_mode_t;

    // ------------------------------------------------------------------------
    // Queue tracker: predicts each tick and checks the served results
    // ------------------------------------------------------------------------
    class task_queue_tracker;
        fts_entry_t         slots[QUEUE_DEPTH];
        int                 head;
        int                 tail;
        int                 fill;
        logic [TICK_W-1:0]  tick;
        logic [ID_W-1:0]    next_id;
        logic [TOTAL_W-1:0] wait_sum;
        fts_result_t        pending_results[$];
        int                 fails;
        int                 checked;
        int                 drops;
        int                 completions;

        function new();
            head = 0;
            tail = 0;
            fill = 0;
            tick = '0;
            next_id = '0;
            wait_sum = '0;
            fails = 0;
            checked = 0;
            drops = 0;
            completions = 0;
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        // Advance the tracked queue by one tick and queue the result it yields
        function void note_tick(logic [IN_TDATA_W-1:0] d);
            logic             arrive;
            logic [SVC_W-1:0] svc;
            logic [WAIT_W-1:0] w;
            logic [TOTAL_W:0] sum;
            fts_result_t      r;
            arrive = d[0];
            svc = d[SVC_W:1];
            r = '0;
            if (arrive)
            begin
                if (fill >= QUEUE_DEPTH)
                begin
                    r.dropped = 1'b1;
                    drops++;
                end
                else
                begin
                    if (svc == 0)
                        svc = SVC_W'(1);
                    if (svc > MAX_SERVICE)
                        svc = SVC_W'(MAX_SERVICE);
                    slots[tail].id = next_id;
                    slots[tail].arrival = tick;
                    slots[tail].svc = svc;
                    tail = (tail + 1) % QUEUE_DEPTH;
                    fill++;
                    next_id = next_id + 1'b1;
                end
            end
            if (fill > 0)
            begin
                r.served_valid = 1'b1;
                r.served_id = slots[head].id;
                if (slots[head].svc > 0)
                    slots[head].svc = slots[head].svc - 1'b1;
                if (slots[head].svc == 0)
                begin
                    w = tick - slots[head].arrival;
                    r.completed = 1'b1;
                    r.task_wait = w;
                    sum = {1'b0, wait_sum} + {{(TOTAL_W + 1 - WAIT_W){1'b0}}, w};
                    wait_sum = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
                    head = (head + 1) % QUEUE_DEPTH;
                    fill--;
                    completions++;
                end
            end
            tick = tick + 1'b1;
            r.wait_total = wait_sum;
            r.tasks_arrived = next_id;
            r.queue_level = LEVEL_W'(fill);
            pending_results.push_back(r);
        endfunction

        function void compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
            if (exp_v !== act_v)
            begin
                $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
                fails++;
            end
        endfunction

        // Compare one output transaction against the oldest queued result
        function void check_served(logic [OUT_TDATA_W-1:0] d);
            fts_result_t r;
            if (pending_results.size() == 0)
            begin
                $error("output transaction with no expected result: %h", d);
                fails++;
                return;
            end
            r = pending_results.pop_front();
            checked++;
            compare_field("served_valid",  r.served_valid,  d[0]);
            compare_field("served_id",     r.served_id,     d[16:1]);
            compare_field("completed",     r.completed,     d[17]);
            compare_field("task_wait",     r.task_wait,     d[33:18]);
            compare_field("wait_total",    r.wait_total,    d[65:34]);
            compare_field("tasks_arrived", r.tasks_arrived, d[81:66]);
            compare_field("queue_level",   r.queue_level,   d[86:82]);
            compare_field("dropped",       r.dropped,       d[87]);
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, DUT and shared signals
    // ------------------------------------------------------------------------
    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    // [0] arrival_valid, [4:1] service_time, [7:5] zero
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    // [0] served_valid, [16:1] served_id, [17] completed, [33:18] task_wait,
    // [65:34] wait_total, [81:66] tasks_arrived, [86:82] queue_level,
    // [87] dropped
    logic [OUT_TDATA_W-1:0] m_tdata;

    task_queue_tracker      tracker;
    bit                     hold_req = 1'b0;
    int                     cycle_count = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    fifo_task_server_with_wait_stats #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .MAX_SERVICE (MAX_SERVICE)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // ------------------------------------------------------------------------
    // Monitor: note accepted inputs first, then check accepted outputs
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if (s_tvalid && s_tready)
                tracker.note_tick(s_tdata);
            if (m_tvalid && m_tready)
                tracker.check_served(m_tdata);
        end
    end

    // ------------------------------------------------------------------------
    // Sender tasks
    // ------------------------------------------------------------------------
    // Offer one tick and hold it until the transaction completes
    task automatic send_tick(input logic [IN_TDATA_W-1:0] d);
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // Drop valid for a number of cycles
    task automatic idle_input(input int n);
        s_tvalid <= 1'b0;
        s_tdata  <= IN_TDATA_W'($urandom_range(0, 255));
        repeat (n) @(posedge clk);
    endtask

    // Drop valid and wait until every expected result has been taken
    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (tracker.pending() > 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Receiver: stall patterns that change over time, plus one long hold-off
    // ------------------------------------------------------------------------
    initial
    begin
        rx_mode_t rx_mode;
        int       rx_left;
        int       phase;
        rx_mode = RX_ALWAYS;
        rx_left = 0;
        phase = 0;
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                // Hold off long enough for the output register to fill and
                // the input side to stall
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else
            begin
                if (rx_left == 0)
                begin
                    rx_mode = rx_mode_t'($urandom_range(0, 3));
                    rx_left = $urandom_range(32, 256);
                end
                rx_left--;
                phase++;
                case (rx_mode)
                    RX_ALWAYS:  m_tready <= 1'b1;
                    RX_MOSTLY:  m_tready <= ($urandom_range(0, 9) < 7);
                    RX_PATTERN: m_tready <= !((phase % 7 == 0) || (phase % 7 == 3));
                    default:    m_tready <= ($urandom_range(0, 9) < 3);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: end the run if it goes far past the slowest correct run
    // ------------------------------------------------------------------------
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycle_count, tracker.pending());
        $display("fifo_task_server_with_wait_stats regression: fail");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Main stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        load_profile_t    profile;
        logic             arrive;
        logic [SVC_W-1:0] svc;
        int               burst_len;
        int               sent;
        int               k;

        tracker  = new();
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty queue: nothing served; ignored service bits must not matter
        send_tick({3'b000, 4'd0, 1'b0});
        send_tick({3'b000, 4'd15, 1'b0});
        // Service time zero is taken as one, above the maximum as the maximum
        send_tick({3'b000, 4'd0, 1'b1});
        send_tick({3'b000, 4'd1, 1'b1});
        send_tick({3'b000, 4'd15, 1'b1});
        send_tick({3'b000, 4'd9, 1'b1});
        // Back-to-back long tasks: fill the queue until arrivals are dropped
        for (k = 0; k < 19; k++)
            send_tick({3'b000, (k % 2) ? 4'd15 : 4'd8, 1'b1});
        idle_input(2);

        // Random bursts with varying load
        sent = 0;
        while (sent < RANDOM_TICKS)
        begin
            burst_len = $urandom_range(1, 40);
            profile = load_profile_t'($urandom_range(0, 3));
            for (k = 0; k < burst_len && sent < RANDOM_TICKS; k++)
            begin
                case (profile)
                    LOAD_LIGHT:
                    begin
                        arrive = ($urandom_range(0, 99) < 15);
                        svc = SVC_W'($urandom_range(1, MAX_SERVICE));
                    end
                    LOAD_HEAVY:
                    begin
                        arrive = ($urandom_range(0, 99) < 90);
                        svc = SVC_W'($urandom_range(4, MAX_SERVICE));
                    end
                    LOAD_BALANCED:
                    begin
                        arrive = ($urandom_range(0, 99) < 25);
                        svc = SVC_W'($urandom_range(1, MAX_SERVICE));
                    end
                    default:
                    begin
                        arrive = 1'($urandom_range(0, 1));
                        svc = SVC_W'($urandom_range(0, 15));
                    end
                endcase
                send_tick({3'b000, svc, arrive});
                sent++;
                // Start the long receiver hold-off and keep offering ticks
                if (sent == HOLD_AT)
                    hold_req = 1'b1;
                // Pause input until all outstanding results are out
                if (sent == DRAIN_AT)
                    wait_results_drained();
            end
            if ($urandom_range(0, 3) != 0)
                idle_input($urandom_range(1, 8));
        end

        // Drain, then watch for stray output transactions
        wait_results_drained();
        repeat (SETTLE) @(posedge clk);

        $display("run covered %0d ticks: %0d tasks completed, %0d arrivals dropped",
                 tracker.checked, tracker.completions, tracker.drops);
        $display("clamped service times, empty-queue ticks, a long output stall and a mid-run drain");
        if (tracker.fails == 0)
            $display("fifo_task_server_with_wait_stats regression: pass");
        else
            $display("fifo_task_server_with_wait_stats regression: fail");
        $finish;
    end

endmodule

FILE: files.f
sv/fts_pkg.sv
sv/fts_ram.sv
sv/fts_engine.sv
sv/fifo_task_server_with_wait_stats.sv
tb/sv/tb_top.sv
